/* hdl/scd_pkg.sv */
// shared types, constants and helpers of the seed chaining core
`default_nettype none
package scd_pkg;

   // predecessor ring
   localparam int Window     = 64;
   localparam int WindowBits = $clog2(Window);
   localparam int FillBits   = $clog2(Window + 1);

   // queue between front and back
   localparam int QueueDepth = 2;
   localparam int QueueBits  = $clog2(QueueDepth);
   localparam int CountBits  = $clog2(QueueDepth + 1);

   localparam logic [30:0] ScoreMax = 31'h7FFF_FFFF;

   // reciprocal of 100 scaled by 2^30, exact for the 23-bit partial dividends used
   localparam logic [23:0] Recip100 = 24'd10737419;
   localparam int          RecipShift = 30;

   // configuration register indexes
   localparam logic [2:0] CsrKmerLen   = 3'd0;
   localparam logic [2:0] CsrMaxSkip   = 3'd1;
   localparam logic [2:0] CsrMaxPred   = 3'd2;
   localparam logic [2:0] CsrJoinDist  = 3'd3;
   localparam logic [2:0] CsrDiagMarg  = 3'd4;

   typedef struct packed {
      logic        list_start;
      logic [30:0] query_pos;
      logic [30:0] target_pos;
      logic [31:0] target_id;
      logic        target_rev;
   } req_type;

   typedef struct packed {
      logic [31:0] hit_number;
      logic [30:0] path_score;
      logic [31:0] best_pred;
      logic [31:0] chain_number;
   } rsp_type;

   typedef struct packed {
      logic [6:0]  kmer_len;
      logic [7:0]  max_skip;
      logic [6:0]  max_predecessors;
      logic [30:0] join_dist;
      logic [30:0] diag_band;
   } cfg_type;

   typedef struct packed {
      logic [30:0] query_pos;
      logic [30:0] target_pos;
      logic [31:0] target_id;
      logic        rev;
      logic [30:0] score;
      logic [31:0] chain;
   } ring_entry_type;

   typedef struct packed {
      logic [FillBits-1:0] fill;
      logic                finishing;
   } back_status_type;

   // floor(log2 v), zero for v of zero or one
   function automatic logic [4:0] floor_log2(input logic [30:0] v);
      logic [4:0] r;
      r = 5'd0;
      for (int i = 1; i < 31; i++) begin
         if (v[i]) begin
            r = 5'(i);
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* hdl/scd_front.sv */
// front end: accepts hits and queues them for the scan engine
`default_nettype none
module scd_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  scd_pkg::req_type             req_data,
   output logic                         q_valid,
   output scd_pkg::req_type             q_data,
   input  wire                          q_pop,
   output logic [scd_pkg::CountBits-1:0] q_count
);

   scd_pkg::req_type                     mem_ff [scd_pkg::QueueDepth];
   logic [scd_pkg::QueueBits-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [scd_pkg::QueueBits-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [scd_pkg::CountBits-1:0]        count_ff, count_in;
   logic                                 push;
   logic                                 pop;

   assign req_ready = (count_ff != scd_pkg::CountBits'(scd_pkg::QueueDepth));
   assign q_valid   = (count_ff != '0);
   assign q_data    = mem_ff[rd_ptr_ff];
   assign q_count   = count_ff;
   assign push      = req_valid && req_ready;
   assign pop       = q_pop && q_valid;

   // pointer and fill update with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == scd_pkg::QueueBits'(scd_pkg::QueueDepth - 1)) ? '0
                     : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == scd_pkg::QueueBits'(scd_pkg::QueueDepth - 1)) ? '0
                     : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule
`default_nettype wire

/* hdl/scd_back.sv */
// back end: predecessor scan, gap penalty, ring store and result register
`default_nettype none
module scd_back (
   input  wire                       clock,
   input  wire                       reset,
   input  scd_pkg::cfg_type          cfg,
   input  wire                       q_valid,
   input  scd_pkg::req_type          q_data,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output scd_pkg::rsp_type          rsp_data,
   output scd_pkg::back_status_type  status
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_SCORE = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   localparam int WB = scd_pkg::WindowBits;
   localparam int FB = scd_pkg::FillBits;

   // ring memory
   scd_pkg::ring_entry_type ring_mem [scd_pkg::Window];
   scd_pkg::ring_entry_type rd_data_ff;
   scd_pkg::ring_entry_type wr_entry;
   logic                    rd_en;
   logic [WB-1:0]           rd_addr;
   logic                    wr_en;

   logic [2:0]        state_ff, state_in;
   scd_pkg::req_type  item_ff, item_in;
   logic [FB-1:0]     back_ff, back_in;
   logic [FB-1:0]     n_ff, n_in;
   logic [30:0]       best_ff, best_in;
   logic [FB-1:0]     best_back_ff, best_back_in;
   logic [31:0]       best_chain_ff, best_chain_in;
   logic              have_ff, have_in;
   logic [8:0]        skip_ff, skip_in;
   logic [31:0]       hit_count_ff, hit_count_in;
   logic [31:0]       chain_count_ff, chain_count_in;
   logic [FB-1:0]     fill_ff, fill_in;
   logic [WB-1:0]     head_ff, head_in;
   logic [30:0]       gap_ff, gap_in;
   logic [6:0]        gain_ff, gain_in;
   logic [30:0]       pscore_ff, pscore_in;
   logic [31:0]       pchain_ff, pchain_in;
   logic [47:0]       prod_ff, prod_in;
   logic [4:0]        lg_ff, lg_in;
   logic [6:0]        rem_ff, rem_in;
   logic [31:0]       quo_ff, quo_in;
   logic [1:0]        div_cnt_ff, div_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   scd_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   // check stage terms
   logic signed [31:0] dq, dt;
   logic signed [32:0] diag;
   logic [32:0]        gap_abs;
   logic               stop_scan, skip_pred;
   logic [31:0]        gain_full;

   // divide stage terms
   logic [15:0]        chunk;
   logic [22:0]        div_x;
   logic [46:0]        div_m;
   logic [15:0]        div_q;
   logic [22:0]        div_back;

   // score stage terms
   logic signed [41:0] sc;
   logic [30:0]        sc_sat;
   logic               improve;

   // start of item terms
   logic [FB-1:0]      limit;
   logic [FB-1:0]      fill_eff;
   logic [31:0]        hitnum;
   logic [31:0]        chain_out;
   logic               out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign status.fill      = fill_ff;
   assign status.finishing = (state_ff == S_DONE) && out_free;

   assign limit = (cfg.max_predecessors == '0 ||
                   FB'(cfg.max_predecessors) > FB'(scd_pkg::Window))
                  ? FB'(scd_pkg::Window) : FB'(cfg.max_predecessors);
   assign fill_eff = q_data.list_start ? '0 : fill_ff;

   assign rd_en   = (state_ff == S_READ);
   assign rd_addr = head_ff - back_ff[WB-1:0];

   // distances to the predecessor just read
   always_comb begin
      dq = $signed({1'b0, item_ff.query_pos}) - $signed({1'b0, rd_data_ff.query_pos});
      dt = $signed({1'b0, item_ff.target_pos}) - $signed({1'b0, rd_data_ff.target_pos});
      diag = 33'(dt) - 33'(dq);
      gap_abs = diag[32] ? 33'(-diag) : 33'(diag);
      stop_scan = (rd_data_ff.target_id != item_ff.target_id) ||
                  (rd_data_ff.rev != item_ff.target_rev) ||
                  (dt > $signed({1'b0, cfg.join_dist}));
      skip_pred = (dq <= 0) || (dt <= 0) ||
                  (gap_abs > {2'b0, cfg.diag_band}) ||
                  (dq > $signed({1'b0, cfg.join_dist}));
      gain_full = (dq < dt) ? dq : dt;
   end

   // one 16-bit digit of the divide by 100
   always_comb begin
      case (div_cnt_ff)
         2'd0:    chunk = prod_ff[47:32];
         2'd1:    chunk = prod_ff[31:16];
         default: chunk = prod_ff[15:0];
      endcase
      div_x    = {rem_ff, chunk};
      div_m    = 47'(div_x) * 47'(scd_pkg::Recip100);
      div_q    = div_m[scd_pkg::RecipShift +: 16];
      div_back = 23'({div_q, 6'b0}) + 23'({div_q, 5'b0}) + 23'({div_q, 2'b0});
   end

   // edge score and saturation
   always_comb begin
      sc = $signed({11'b0, pscore_ff}) + $signed({35'b0, gain_ff})
           - $signed({10'b0, quo_ff}) - $signed({38'b0, lg_ff[4:1]});
      sc_sat  = (sc > $signed({11'b0, scd_pkg::ScoreMax})) ? scd_pkg::ScoreMax
                : sc[30:0];
      improve = (sc >= $signed({11'b0, best_ff}));
   end

   assign hitnum    = hit_count_ff + 1'b1;
   assign chain_out = have_ff ? best_chain_ff : chain_count_ff;

   always_comb begin
      wr_entry.query_pos  = item_ff.query_pos;
      wr_entry.target_pos = item_ff.target_pos;
      wr_entry.target_id  = item_ff.target_id;
      wr_entry.rev        = item_ff.target_rev;
      wr_entry.score      = best_ff;
      wr_entry.chain      = chain_out;
   end

   // scan sequencer
   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      back_in        = back_ff;
      n_in           = n_ff;
      best_in        = best_ff;
      best_back_in   = best_back_ff;
      best_chain_in  = best_chain_ff;
      have_in        = have_ff;
      skip_in        = skip_ff;
      hit_count_in   = hit_count_ff;
      chain_count_in = chain_count_ff;
      fill_in        = fill_ff;
      head_in        = head_ff;
      gap_in         = gap_ff;
      gain_in        = gain_ff;
      pscore_in      = pscore_ff;
      pchain_in      = pchain_ff;
      prod_in        = prod_ff;
      lg_in          = lg_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      div_cnt_in     = div_cnt_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      q_pop          = 1'b0;
      wr_en          = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop        = 1'b1;
               item_in      = q_data;
               fill_in      = fill_eff;
               if (q_data.list_start) begin
                  hit_count_in   = '0;
                  chain_count_in = '0;
               end
               n_in          = (fill_eff < limit) ? fill_eff : limit;
               back_in       = FB'(1);
               best_in       = {24'b0, cfg.kmer_len};
               best_back_in  = '0;
               have_in       = 1'b0;
               skip_in       = '0;
               state_in      = (fill_eff == '0) ? S_DONE : S_READ;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            pscore_in = rd_data_ff.score;
            pchain_in = rd_data_ff.chain;
            gap_in    = gap_abs[30:0];
            gain_in   = (gain_full > {25'b0, cfg.kmer_len}) ? cfg.kmer_len
                        : gain_full[6:0];
            if (stop_scan) begin
               state_in = S_DONE;
            end else if (skip_pred) begin
               if (back_ff == n_ff) begin
                  state_in = S_DONE;
               end else begin
                  back_in  = back_ff + 1'b1;
                  state_in = S_READ;
               end
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in    = {10'b0, 38'(gap_ff) * 38'(cfg.kmer_len)};
            lg_in      = scd_pkg::floor_log2(gap_ff);
            rem_in     = '0;
            quo_in     = '0;
            div_cnt_in = '0;
            state_in   = S_DIV;
         end
         S_DIV: begin
            quo_in     = {quo_ff[15:0], div_q};
            rem_in     = 7'(div_x - div_back);
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == 2'd2) begin
               state_in = S_SCORE;
            end
         end
         S_SCORE: begin
            if (improve) begin
               best_in       = sc_sat;
               best_back_in  = back_ff;
               best_chain_in = pchain_ff;
               have_in       = 1'b1;
               if (skip_ff != '0) begin
                  skip_in = skip_ff - 1'b1;
               end
            end else begin
               skip_in = skip_ff + 1'b1;
            end
            if (!improve && (skip_ff + 1'b1 > {1'b0, cfg.max_skip})) begin
               state_in = S_DONE;
            end else if (back_ff == n_ff) begin
               state_in = S_DONE;
            end else begin
               back_in  = back_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_DONE: begin
            if (out_free) begin
               wr_en        = 1'b1;
               hit_count_in = hitnum;
               if (!have_ff) begin
                  chain_count_in = chain_count_ff + 1'b1;
               end
               head_in = head_ff + 1'b1;
               if (fill_ff < FB'(scd_pkg::Window)) begin
                  fill_in = fill_ff + 1'b1;
               end
               rsp_valid_in             = 1'b1;
               rsp_data_in.hit_number   = hitnum;
               rsp_data_in.path_score   = best_ff;
               rsp_data_in.best_pred    = have_ff ? hitnum - 32'(best_back_ff) : '0;
               rsp_data_in.chain_number = chain_out;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         hit_count_ff   <= '0;
         chain_count_ff <= '0;
         fill_ff        <= '0;
         head_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         hit_count_ff   <= hit_count_in;
         chain_count_ff <= chain_count_in;
         fill_ff        <= fill_in;
         head_ff        <= head_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      back_ff       <= back_in;
      n_ff          <= n_in;
      best_ff       <= best_in;
      best_back_ff  <= best_back_in;
      best_chain_ff <= best_chain_in;
      have_ff       <= have_in;
      skip_ff       <= skip_in;
      gap_ff        <= gap_in;
      gain_ff       <= gain_in;
      pscore_ff     <= pscore_in;
      pchain_ff     <= pchain_in;
      prod_ff       <= prod_in;
      lg_ff         <= lg_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      div_cnt_ff    <= div_cnt_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // ring memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[head_ff] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

/* hdl/seed_chain_dp_core.sv */
// top level of the seed chaining core: registers, front queue and scan engine
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  req_data (list_start, positions, id, strand)
//  rsp      out        rsp_valid / rsp_ready  rsp_data (hit number, score, pred, chain)
//  csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// for each hit the engine reads and checks each examined predecessor; one that is
// skipped or stops the scan goes no further, and one that is scored then goes through
// multiply, three divide digits and compare
// reset is synchronous and clears counters, ring fill and handshake state
// a two-deep queue takes hits while the scan runs; a held result stalls the scan
`default_nettype none
module seed_chain_dp_core (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  scd_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output scd_pkg::rsp_type  rsp_data,
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire [2:0]         csr_index,
   input  wire [30:0]        csr_data
);

   scd_pkg::cfg_type                  cfg_ff, cfg_in;
   logic                              q_valid;
   scd_pkg::req_type                  q_data;
   logic                              q_pop;
   logic [scd_pkg::CountBits-1:0]     q_count;
   scd_pkg::back_status_type          status;

   assign csr_ready = 1'b1;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            scd_pkg::CsrKmerLen:  cfg_in.kmer_len         = csr_data[6:0];
            scd_pkg::CsrMaxSkip:  cfg_in.max_skip         = csr_data[7:0];
            scd_pkg::CsrMaxPred:  cfg_in.max_predecessors = csr_data[6:0];
            scd_pkg::CsrJoinDist: cfg_in.join_dist        = csr_data;
            scd_pkg::CsrDiagMarg: cfg_in.diag_band        = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kmer_len         <= 7'd15;
         cfg_ff.max_skip         <= 8'd25;
         cfg_ff.max_predecessors <= 7'd64;
         cfg_ff.join_dist        <= 31'd5000;
         cfg_ff.diag_band        <= 31'd500;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   scd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .q_count   (q_count)
   );

   scd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .status    (status)
   );

   // ring fill never passes the window
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      status.fill <= scd_pkg::FillBits'(scd_pkg::Window))
      else $error("ring fill above window");

   // queue occupancy stays within its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= scd_pkg::CountBits'(scd_pkg::QueueDepth))
      else $error("queue occupancy above depth");

   // a new result only follows a finished scan
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(status.finishing))
      else $error("result without finished scan");

   // the engine only pops a queued hit
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

endmodule
`default_nettype wire

/* tb/tb.sv */
// testbench of the seed chaining core: directed, register sweep, random and back-pressure tests
`timescale 1ns / 1ps
`default_nettype none
module tb;

   localparam int  HistDepth = 64;
   localparam int  SettleCycles = 600;
   localparam logic [30:0] PosMax = 31'h7FFF_FFFF;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   scd_pkg::req_type  req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   scd_pkg::rsp_type  rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [2:0]        csr_index;
   logic [30:0]       csr_data;

   seed_chain_dp_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // predictor state: register copy and history of recent hits
   scd_pkg::cfg_type cfg;
   logic [30:0] hist_q     [HistDepth];
   logic [30:0] hist_t     [HistDepth];
   logic [31:0] hist_id    [HistDepth];
   logic        hist_rev   [HistDepth];
   logic [30:0] hist_score [HistDepth];
   logic [31:0] hist_chain [HistDepth];
   logic [31:0] hit_total, chain_total;
   int          hist_fill;
   logic [5:0]  hist_head;

   scd_pkg::rsp_type pending_rsp [$];
   int          errors = 0;
   int          hits_sent = 0;
   int          rsps_seen = 0;
   int          chained_hits = 0;
   bit          idle_on = 0;
   int          hold_cycles = 0;

   // clock
   initial clock = 0;
   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // scores one hit against the history and updates it
   function automatic scd_pkg::rsp_type chain_predict(scd_pkg::req_type h);
      scd_pkg::rsp_type r;
      int          limit, n, skipped;
      longint      k, qi, ti, qj, tj, dq, dt, gap, pen, gain, sc, best, g;
      logic [5:0]  e;
      logic [31:0] best_back, best_chain, chain_out;
      bit          have_pred;
      int          lg;
      k = longint'(cfg.kmer_len);
      qi = longint'(h.query_pos);
      ti = longint'(h.target_pos);
      best = k;
      best_back = 0;
      best_chain = 0;
      have_pred = 0;
      skipped = 0;
      if (h.list_start) begin
         hit_total = 0;
         chain_total = 0;
         hist_fill = 0;
      end
      limit = int'(cfg.max_predecessors);
      if (limit == 0 || limit > HistDepth) limit = HistDepth;
      n = (hist_fill < limit) ? hist_fill : limit;
      for (int back = 1; back <= n; back++) begin
         e = hist_head - 6'(back);
         qj = longint'(hist_q[e]);
         tj = longint'(hist_t[e]);
         dq = qi - qj;
         dt = ti - tj;
         gap = (dq < dt) ? dt - dq : dq - dt;
         if (hist_id[e] != h.target_id || hist_rev[e] != h.target_rev) break;
         if (dt > longint'(cfg.join_dist)) break;
         if (dq <= 0 || dt <= 0) continue;
         if (gap > longint'(cfg.diag_band)) continue;
         if (dq > longint'(cfg.join_dist)) continue;
         pen = (gap * k) / 100;
         // integer log2 of the diagonal gap, halved
         lg = 0;
         g = gap;
         while (g > 1) begin
            g = g >> 1;
            lg++;
         end
         if (gap > 0) pen += longint'(lg >> 1);
         gain = (dq < dt) ? dq : dt;
         if (gain > k) gain = k;
         sc = longint'(hist_score[e]) + gain - pen;
         if (sc > longint'(scd_pkg::ScoreMax)) sc = longint'(scd_pkg::ScoreMax);
         if (sc >= best) begin
            best = sc;
            best_back = 32'(back);
            best_chain = hist_chain[e];
            have_pred = 1;
            if (skipped > 0) skipped--;
         end else begin
            skipped++;
            if (skipped > int'(cfg.max_skip)) break;
         end
      end
      hit_total = hit_total + 1;
      if (have_pred) begin
         chain_out = best_chain;
      end else begin
         chain_out = chain_total;
         chain_total = chain_total + 1;
      end
      hist_q[hist_head] = h.query_pos;
      hist_t[hist_head] = h.target_pos;
      hist_id[hist_head] = h.target_id;
      hist_rev[hist_head] = h.target_rev;
      hist_score[hist_head] = best[30:0];
      hist_chain[hist_head] = chain_out;
      hist_head = hist_head + 1'b1;
      if (hist_fill < HistDepth) hist_fill++;
      r.hit_number = hit_total;
      r.path_score = best[30:0];
      r.best_pred = have_pred ? hit_total - best_back : 32'd0;
      r.chain_number = chain_out;
      return r;
   endfunction

   // sends one hit and records its expected result on transfer
   task automatic send_hit(scd_pkg::req_type h);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_valid <= 0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_valid <= 1;
      req_data <= h;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(chain_predict(h));
      hits_sent++;
   endtask

   function automatic scd_pkg::req_type mk(bit ls, logic [30:0] q, logic [30:0] t,
                                           logic [31:0] id, bit rev);
      scd_pkg::req_type h;
      h.list_start = ls;
      h.query_pos = q;
      h.target_pos = t;
      h.target_id = id;
      h.target_rev = rev;
      return h;
   endfunction

   // drops valid and waits until all results are back and the core has settled
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [30:0] value);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
      case (idx)
         scd_pkg::CsrKmerLen:  cfg.kmer_len = value[6:0];
         scd_pkg::CsrMaxSkip:  cfg.max_skip = value[7:0];
         scd_pkg::CsrMaxPred:  cfg.max_predecessors = value[6:0];
         scd_pkg::CsrJoinDist: cfg.join_dist = value;
         scd_pkg::CsrDiagMarg: cfg.diag_band = value;
         default: ;
      endcase
   endtask

   task automatic set_all(logic [30:0] k, logic [30:0] skip, logic [30:0] pred,
                          logic [30:0] join_d, logic [30:0] diag);
      wait_idle();
      csr_write(scd_pkg::CsrKmerLen, k);
      csr_write(scd_pkg::CsrMaxSkip, skip);
      csr_write(scd_pkg::CsrMaxPred, pred);
      csr_write(scd_pkg::CsrJoinDist, join_d);
      csr_write(scd_pkg::CsrDiagMarg, diag);
   endtask

   // one sorted list along a rough diagonal, with occasional broken hits
   task automatic send_list(int len, int noise_pct);
      logic [30:0] q, t;
      logic [31:0] id;
      bit          rev;
      int          step;
      q = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 100000));
      t = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 100000));
      id = ($urandom_range(0, 1) == 0) ? $urandom : 32'($urandom_range(0, 3));
      rev = 1'($urandom_range(0, 1));
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(1, 100) <= noise_pct) begin
            case ($urandom_range(0, 3))
               0: send_hit(mk(0, 31'($urandom), 31'($urandom), $urandom,
                              1'($urandom_range(0, 1))));
               1: send_hit(mk(0, q, t, id ^ 32'd1, rev));
               2: send_hit(mk(0, q, t, id, !rev));
               default: send_hit(mk(0, q + 31'($urandom_range(0, 8000)), t, id, rev));
            endcase
         end else begin
            step = $urandom_range(0, 60);
            q = q + 31'(step);
            t = t + 31'(step) + 31'($urandom_range(0, 20)) - 31'd10;
            if ($urandom_range(0, 30) == 0) t = t + 31'($urandom_range(0, 3000));
            send_hit(mk(i == 0, q, t, id, rev));
         end
      end
   endtask

   task automatic random_config();
      int sel;
      sel = $urandom_range(0, 3);
      set_all(31'($urandom_range(1, 64)), 31'($urandom_range(0, 255)),
              31'($urandom_range(0, 127)),
              sel == 0 ? 31'd0 : sel == 1 ? PosMax : 31'($urandom_range(10, 6000)),
              sel == 2 ? 31'd0 : sel == 3 ? PosMax : 31'($urandom_range(0, 800)));
   endtask

   // receiver: random stall bursts and one long hold-off on request
   initial begin
      int burst;
      burst = 0;
      rsp_ready = 1;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 0;
            hold_cycles--;
         end else if (burst > 0) begin
            rsp_ready <= 0;
            burst--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 0;
            burst = $urandom_range(0, 9);
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      scd_pkg::rsp_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         rsps_seen++;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            errors++;
         end else begin
            exp_r = pending_rsp.pop_front();
            if (exp_r.best_pred != 0) chained_hits++;
            if (rsp_data.hit_number !== exp_r.hit_number) begin
               $display("%0t: hit_number expected %0d actual %0d",
                        $time, exp_r.hit_number, rsp_data.hit_number);
               errors++;
            end
            if (rsp_data.path_score !== exp_r.path_score) begin
               $display("%0t: path_score expected %0d actual %0d",
                        $time, exp_r.path_score, rsp_data.path_score);
               errors++;
            end
            if (rsp_data.best_pred !== exp_r.best_pred) begin
               $display("%0t: best_pred expected %0d actual %0d",
                        $time, exp_r.best_pred, rsp_data.best_pred);
               errors++;
            end
            if (rsp_data.chain_number !== exp_r.chain_number) begin
               $display("%0t: chain_number expected %0d actual %0d",
                        $time, exp_r.chain_number, rsp_data.chain_number);
               errors++;
            end
         end
      end
   end

   // edge cases of positions, strand, target and distances under reset settings
   task automatic test_directed();
      send_hit(mk(1, 100, 1000, 7, 0));
      send_hit(mk(0, 120, 1020, 7, 0));
      send_hit(mk(0, 150, 1055, 7, 0));
      send_hit(mk(0, 150, 1090, 7, 0));
      send_hit(mk(0, 400, 1700, 7, 0));
      send_hit(mk(0, 2000, 1800, 7, 0));
      send_hit(mk(0, 2100, 8000, 7, 0));
      send_hit(mk(0, 2110, 8010, 7, 1));
      send_hit(mk(0, 2120, 8020, 9, 1));
      send_hit(mk(0, 2130, 8030, 9, 1));
      send_hit(mk(1, 0, 0, 0, 0));
      send_hit(mk(0, PosMax, PosMax, 32'hFFFF_FFFF, 1));
      send_hit(mk(1, PosMax - 40, PosMax - 40, 32'hFFFF_FFFF, 1));
      send_hit(mk(0, PosMax - 20, PosMax - 20, 32'hFFFF_FFFF, 1));
      send_hit(mk(0, PosMax, PosMax - 10, 32'hFFFF_FFFF, 1));
      send_hit(mk(0, 5, 5, 32'hFFFF_FFFF, 1));
      send_hit(mk(0, 10, 10, 32'hFFFF_FFFF, 1));
   endtask

   // every register at both ends (k-mer length up to 64 only) and a few values between
   task automatic test_register_sweep();
      set_all(1, 0, 1, 0, 0);
      send_list(20, 10);
      set_all(64, 255, 64, PosMax, PosMax);
      send_list(70, 5);
      set_all(0, 1, 0, 100, 5);
      send_list(30, 10);
      set_all(32, 3, 127, 5000, 500);
      send_list(30, 10);
      set_all(15, 25, 64, 5000, 500);
   endtask

   // random lists under random settings with idling on both sides
   task automatic test_random(int target_hits);
      int start;
      start = hits_sent;
      idle_on = 1;
      while (hits_sent - start < target_hits) begin
         if ($urandom_range(0, 3) == 0) random_config();
         send_list($urandom_range(1, 90), $urandom_range(0, 4) == 0 ? 40 : 5);
      end
   endtask

   // long receiver hold-off while hits keep coming
   task automatic test_backpressure();
      wait_idle();
      @(negedge clock);
      hold_cycles = 400;
      send_list(40, 0);
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_valid = 0;
      csr_index = scd_pkg::CsrKmerLen;
      csr_data = '0;
      cfg.kmer_len = 15;
      cfg.max_skip = 25;
      cfg.max_predecessors = 64;
      cfg.join_dist = 5000;
      cfg.diag_band = 500;
      hit_total = 0;
      chain_total = 0;
      hist_fill = 0;
      hist_head = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      test_directed();
      test_register_sweep();
      test_random(1100);
      test_backpressure();
      test_random(100);
      wait_idle();
      idle_on = 0;
      test_random(150);
      wait_idle();

      $display("covered %0d hits in sorted and broken lists, %0d results, %0d chained",
               hits_sent, rsps_seen, chained_hits);
      $display("registers swept over both ends, idling and a long result stall included");
      if (errors == 0) begin
         $display("PASS seed_chain_dp_core");
      end else begin
         $display("FAIL seed_chain_dp_core");
      end
      $finish;
   end

   // run limit
   initial begin
      #40_000_000;
      $display("FAIL seed_chain_dp_core");
      $finish;
   end

endmodule
`default_nettype wire

/* sim.f */
hdl/scd_pkg.sv
hdl/scd_front.sv
hdl/scd_back.sv
hdl/seed_chain_dp_core.sv
tb/tb.sv
